[src/mm4_pkg.sv]
// Shared types and defaults for the 4x4 matrix multiply unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package mm4_pkg;

  // Element index width: sixteen column-major positions
  localparam int unsigned IDX_W = 4;
  // Product-term index within one result
  localparam int unsigned K_W = 2;
  // Sequencer step index width: 16 results times 4 products
  localparam int unsigned STEP_W = IDX_W + K_W;

  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF = 16;

  // Tag that travels with each memory read down the multiply pipeline
  typedef struct packed {
    logic             vld;
    logic [K_W-1:0]   k;
    logic [IDX_W-1:0] idx;
  } mac_tag_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } seq_state_e;

endpackage

`default_nettype wire

[src/mm4_store.sv]
// Element stores for both matrices: one write port, one registered read port each.
// Depends on mm4_pkg.
`default_nettype none

module mm4_store
  import mm4_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  wr_en_i,
  input  wire logic [IDX_W-1:0]      wr_addr_i,
  input  wire logic [DATA_WIDTH-1:0] wr_left_i,
  input  wire logic [DATA_WIDTH-1:0] wr_right_i,
  input  wire logic                  rd_en_i,
  input  wire logic [IDX_W-1:0]      rd_left_addr_i,
  input  wire logic [IDX_W-1:0]      rd_right_addr_i,
  output logic      [DATA_WIDTH-1:0] rd_left_o,
  output logic      [DATA_WIDTH-1:0] rd_right_o
);

  localparam int unsigned DEPTH = 1 << IDX_W;

  logic [DATA_WIDTH-1:0] left_mem [DEPTH];
  logic [DATA_WIDTH-1:0] right_mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_left_q;
  logic [DATA_WIDTH-1:0] rd_right_q;

  // Store loaded elements
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      left_mem[wr_addr_i]  <= wr_left_i;
      right_mem[wr_addr_i] <= wr_right_i;
    end
  end

  // Read one operand pair per cycle while rd_en_i is high; the read data is registered
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_left_q  <= left_mem[rd_left_addr_i];
      rd_right_q <= right_mem[rd_right_addr_i];
    end
  end

  assign rd_left_o  = rd_left_q;
  assign rd_right_o = rd_right_q;

endmodule

`default_nettype wire

[src/mm4_mac.sv]
// Multiply-accumulate datapath: product register, four-term accumulator,
// then arithmetic shift and saturation into the result register. Depends on mm4_pkg.
`default_nettype none

module mm4_mac
  import mm4_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire mac_tag_t              tag_i,
  input  wire logic [DATA_WIDTH-1:0] left_i,
  input  wire logic [DATA_WIDTH-1:0] right_i,
  output logic                       res_vld_o,
  output logic      [IDX_W-1:0]      res_idx_o,
  output logic      [DATA_WIDTH-1:0] res_val_o,
  output logic                       res_last_o
);

  localparam int unsigned PROD_W = 2 * DATA_WIDTH;
  localparam int unsigned ACC_W  = PROD_W + 2;
  localparam int unsigned HEAD_W = ACC_W - DATA_WIDTH + 1;
  localparam logic [IDX_W-1:0] IDX_LAST = {IDX_W{1'b1}};
  localparam logic [K_W-1:0]   K_FIRST  = '0;
  localparam logic [K_W-1:0]   K_LAST   = {K_W{1'b1}};

  mac_tag_t                  mul_tag_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [PROD_W-1:0]  prod_d;
  logic signed [ACC_W-1:0]   acc_q;
  logic signed [ACC_W-1:0]   acc_d;
  logic signed [ACC_W-1:0]   prod_ext;
  logic                      sum_vld_q;
  logic [IDX_W-1:0]          sum_idx_q;
  logic signed [ACC_W-1:0]   sum_q;
  logic signed [ACC_W-1:0]   shifted;
  logic [HEAD_W-1:0]         head;
  logic [DATA_WIDTH-1:0]     sat_val;
  logic                      res_vld_q;
  logic [IDX_W-1:0]          res_idx_q;
  logic [DATA_WIDTH-1:0]     res_val_q;

  // Exact signed product of the operand pair
  assign prod_d = $signed(left_i) * $signed(right_i);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_tag_q <= '0;
    end else begin
      mul_tag_q <= tag_i;
    end
  end

  // Accumulate four products; restart on the first term
  assign prod_ext = {{2{prod_q[PROD_W-1]}}, prod_q};
  assign acc_d    = (mul_tag_q.k == K_FIRST) ? prod_ext : acc_q + prod_ext;

  always_ff @(posedge clk_i) begin
    if (mul_tag_q.vld) begin
      acc_q <= acc_d;
    end
    if (mul_tag_q.vld && mul_tag_q.k == K_LAST) begin
      sum_q     <= acc_d;
      sum_idx_q <= mul_tag_q.idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_vld_q <= 1'b0;
    end else begin
      sum_vld_q <= mul_tag_q.vld && mul_tag_q.k == K_LAST;
    end
  end

  // Drop fraction bits, then clamp to the signed data range
  assign shifted = sum_q >>> FRAC_BITS;
  assign head    = shifted[ACC_W-1:DATA_WIDTH-1];

  always_comb begin
    if (head == '0 || head == '1) begin
      sat_val = shifted[DATA_WIDTH-1:0];
    end else if (shifted[ACC_W-1]) begin
      sat_val = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_vld_q) begin
      res_val_q <= sat_val;
      res_idx_q <= sum_idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= sum_vld_q;
    end
  end

  assign res_vld_o  = res_vld_q;
  assign res_idx_o  = res_idx_q;
  assign res_val_o  = res_val_q;
  assign res_last_o = res_idx_q == IDX_LAST;

endmodule

`default_nettype wire

[src/matrix4x4_multiply_unit.sv]
// 4x4 matrix multiply unit: load one element pair per request, multiply on last.
// A request without the last mark only stores its pair; a last-marked request starts
// the sequencer, and each product passes the store read register, product register,
// accumulator and result register (one multiplier, one memory read pair per product).
// busy stays high until the final result strobe. Reset clears the sequencer and
// pipeline valids; the element stores hold undefined data until loaded.
// The result receiver cannot stall. Depends on mm4_pkg, mm4_store and mm4_mac.
`default_nettype none

module matrix4x4_multiply_unit
  import mm4_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [IDX_W-1:0]      element_index_i,
  input  wire logic [DATA_WIDTH-1:0] left_value_i,
  input  wire logic [DATA_WIDTH-1:0] right_value_i,
  input  wire logic                  last_element_i,
  output logic                       result_strobe_o,
  output logic      [IDX_W-1:0]      result_index_o,
  output logic      [DATA_WIDTH-1:0] result_value_o,
  output logic                       last_result_o
);

  localparam logic [STEP_W-1:0] STEP_LAST = {STEP_W{1'b1}};

  seq_state_e          state_q, state_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic                busy_q, busy_d;
  logic                accept;
  logic                reading;
  logic [IDX_W-1:0]    rd_left_addr;
  logic [IDX_W-1:0]    rd_right_addr;
  mac_tag_t            rd_tag_q;
  logic [DATA_WIDTH-1:0] rd_left;
  logic [DATA_WIDTH-1:0] rd_right;
  logic                res_vld;
  logic                res_last;

  assign accept  = start && !busy_q;
  assign reading = state_q == ST_RUN;

  // Step layout: column, row, term; right reads (column, term), left (term, row)
  assign rd_right_addr = {step_q[STEP_W-1:STEP_W-2], step_q[K_W-1:0]};
  assign rd_left_addr  = {step_q[K_W-1:0], step_q[STEP_W-3:STEP_W-4]};

  // Sequence the 64 operand reads after the last-marked request
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    busy_d  = busy_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && last_element_i) begin
          state_d = ST_RUN;
          step_d  = '0;
          busy_d  = 1'b1;
        end
      end
      ST_RUN: begin
        step_d = step_q + 1'b1;
        if (step_q == STEP_LAST) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    // Release on the final result
    if (res_vld && res_last) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      step_q   <= '0;
      busy_q   <= 1'b0;
      rd_tag_q <= '0;
    end else begin
      state_q      <= state_d;
      step_q       <= step_d;
      busy_q       <= busy_d;
      rd_tag_q.vld <= reading;
      rd_tag_q.k   <= step_q[K_W-1:0];
      rd_tag_q.idx <= step_q[STEP_W-1:K_W];
    end
  end

  mm4_store #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_store (
    .clk_i          (clk_i),
    .wr_en_i        (accept),
    .wr_addr_i      (element_index_i),
    .wr_left_i      (left_value_i),
    .wr_right_i     (right_value_i),
    .rd_en_i        (reading),
    .rd_left_addr_i (rd_left_addr),
    .rd_right_addr_i(rd_right_addr),
    .rd_left_o      (rd_left),
    .rd_right_o     (rd_right)
  );

  mm4_mac #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .tag_i     (rd_tag_q),
    .left_i    (rd_left),
    .right_i   (rd_right),
    .res_vld_o (res_vld),
    .res_idx_o (result_index_o),
    .res_val_o (result_value_o),
    .res_last_o(res_last)
  );

  assign busy            = busy_q;
  assign result_strobe_o = res_vld;
  assign last_result_o   = res_last;

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking bench for matrix4x4_multiply_unit: loads element pairs, then runs multiplies.
// Directed rows come first, then random matrix loads; hand-typed values or a built-in Q16.16 predictor check results.
// Depends on mm4_pkg and matrix4x4_multiply_unit.
`default_nettype none

module tb
  import mm4_pkg::*;
();

  localparam int unsigned DW = 32;
  localparam int unsigned FRAC = 16;
  localparam int unsigned LOAD_TARGET = 460;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned TAIL_CYCLES = 80;
  localparam logic signed [2*DW+1:0] SAT_HI = 66'sd2147483647;
  localparam logic signed [2*DW+1:0] SAT_LO = -66'sd2147483648;
  localparam logic [DW-1:0] Q_ONE = 32'h0001_0000;
  localparam logic [DW-1:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [DW-1:0] Q_MIN = 32'h8000_0000;
  localparam logic [DW-1:0] Q_NEG_LSB = 32'hFFFF_FFFF;

  // Value classes for random element content
  localparam int unsigned VAL_SMALL = 0;
  localparam int unsigned VAL_FULL = 1;
  localparam int unsigned VAL_EDGE = 2;
  localparam int unsigned VAL_MIXED = 3;

  // One load request, with optional hand-typed product pattern
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [DW-1:0]    left_val;
    logic [DW-1:0]    right_val;
    logic             lst;
    logic             typed;
    logic [DW-1:0]    at_zero;
    logic [DW-1:0]    on_diag;
    logic [DW-1:0]    off_diag;
  } load_row_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [DW-1:0]    value;
    logic             last;
  } product_elem_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [IDX_W-1:0] element_index_i = '0;
  logic [DW-1:0]    left_value_i = '0;
  logic [DW-1:0]    right_value_i = '0;
  logic             last_element_i = 1'b0;
  logic             result_strobe_o;
  logic [IDX_W-1:0] result_index_o;
  logic [DW-1:0]    result_value_o;
  logic             last_result_o;

  // Predictor copy of both element stores
  logic [DW-1:0]    left_mat [16];
  logic [DW-1:0]    right_mat [16];
  product_elem_t    queued_products [$];
  load_row_t        stim_rows [$];

  int unsigned mismatches = 0;
  int unsigned loads_sent = 0;
  int unsigned multiplies = 0;
  int unsigned products_seen = 0;
  int unsigned cycle_count = 0;

  matrix4x4_multiply_unit #(
    .DATA_WIDTH(DW),
    .FRAC_BITS (FRAC)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .element_index_i(element_index_i),
    .left_value_i   (left_value_i),
    .right_value_i  (right_value_i),
    .last_element_i (last_element_i),
    .result_strobe_o(result_strobe_o),
    .result_index_o (result_index_o),
    .result_value_o (result_value_o),
    .last_result_o  (last_result_o)
  );

  always #4 clk_i = ~clk_i;

  // Exact sum of four products, floor shift, clamp to the signed data range
  function automatic logic [DW-1:0] mat_product_element(int unsigned col, int unsigned row);
    logic signed [2*DW+1:0] sum;
    int unsigned k;
    sum = '0;
    for (k = 0; k < 4; k++)
      sum = sum + $signed(right_mat[col*4+k]) * $signed(left_mat[k*4+row]);
    sum = sum >>> FRAC;
    if (sum > SAT_HI) return Q_MAX;
    if (sum < SAT_LO) return Q_MIN;
    return sum[DW-1:0];
  endfunction

  function automatic logic [DW-1:0] pick_value(int unsigned vmode);
    int unsigned m;
    int s;
    m = (vmode == VAL_MIXED) ? $urandom_range(VAL_SMALL, VAL_EDGE) : vmode;
    case (m)
      VAL_SMALL: begin
        // roughly +-4.0, keeps most sums inside the range
        s = int'($urandom_range(0, 524287)) - 262144;
        return s;
      end
      VAL_FULL: return $urandom;
      default: begin
        case ($urandom_range(0, 5))
          0: return Q_MAX;
          1: return Q_MIN;
          2: return '0;
          3: return Q_ONE;
          4: return Q_NEG_LSB;
          default: return $urandom;
        endcase
      end
    endcase
  endfunction

  task automatic add_row(input logic [IDX_W-1:0] idx, input logic [DW-1:0] lv, rv,
                         input logic lst, typed, input logic [DW-1:0] e0, ed, eo);
    load_row_t row;
    row.idx = idx;
    row.left_val = lv;
    row.right_val = rv;
    row.lst = lst;
    row.typed = typed;
    row.at_zero = e0;
    row.on_diag = ed;
    row.off_diag = eo;
    stim_rows.push_back(row);
  endtask

  // Update the stores on an accepted request; queue sixteen products on last
  task automatic queue_products(input load_row_t row);
    product_elem_t pe;
    int unsigned pos;
    left_mat[row.idx] = row.left_val;
    right_mat[row.idx] = row.right_val;
    loads_sent++;
    if (row.lst) begin
      multiplies++;
      for (pos = 0; pos < 16; pos++) begin
        pe.idx = pos[IDX_W-1:0];
        pe.last = (pos == 15);
        if (!row.typed)
          pe.value = mat_product_element(pos / 4, pos % 4);
        else if (pos == 0)
          pe.value = row.at_zero;
        else if (pos % 5 == 0)
          pe.value = row.on_diag;
        else
          pe.value = row.off_diag;
        queued_products.push_back(pe);
      end
    end
  endtask

  // Idle for gap cycles with noise on the fields, then hold the request until accepted
  task automatic load_pair(input load_row_t row, input int unsigned gap);
    if (gap > 0) begin
      start <= 1'b0;
      element_index_i <= IDX_W'($urandom);
      left_value_i <= $urandom;
      right_value_i <= $urandom;
      last_element_i <= 1'($urandom);
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    element_index_i <= row.idx;
    left_value_i <= row.left_val;
    right_value_i <= row.right_val;
    last_element_i <= row.lst;
    do @(posedge clk_i); while (busy);
    queue_products(row);
  endtask

  // Check each result strobe against the oldest queued product
  always @(posedge clk_i) begin : result_check
    product_elem_t want;
    if (rst_ni && result_strobe_o) begin
      products_seen++;
      if (queued_products.size() == 0) begin
        $display("%0t: unexpected result idx %0d value %h last %b", $time,
                 result_index_o, result_value_o, last_result_o);
        mismatches++;
      end else begin
        want = queued_products.pop_front();
        if (result_index_o !== want.idx) begin
          $display("%0t: result index expected %0d, got %0d", $time, want.idx, result_index_o);
          mismatches++;
        end
        if (result_value_o !== want.value) begin
          $display("%0t: result value at idx %0d expected %h, got %h", $time, want.idx,
                   want.value, result_value_o);
          mismatches++;
        end
        if (last_result_o !== want.last) begin
          $display("%0t: last flag at idx %0d expected %b, got %b", $time, want.idx,
                   want.last, last_result_o);
          mismatches++;
        end
      end
    end
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d products still queued", cycle_count,
               queued_products.size());
      $display("matrix4x4_multiply_unit: mismatch");
      $finish;
    end
  end

  initial begin : stimulus
    load_row_t row;
    int unsigned i, j, n, tmp, kind, vmode;
    int unsigned order [16];
    logic burst;

    // Identity times identity, every index written before the first multiply
    for (i = 0; i < 16; i++)
      add_row(IDX_W'(i), (i % 5 == 0) ? Q_ONE : '0, (i % 5 == 0) ? Q_ONE : '0, i == 15,
              1'b1, Q_ONE, Q_ONE, '0);
    // Corner products through element zero: saturation both ways, floor rounding
    add_row('0, Q_MAX, Q_MAX, 1'b1, 1'b1, Q_MAX, Q_ONE, '0);
    add_row('0, Q_MIN, Q_MAX, 1'b1, 1'b1, Q_MIN, Q_ONE, '0);
    add_row('0, Q_MIN, Q_MIN, 1'b1, 1'b1, Q_MAX, Q_ONE, '0);
    add_row('0, Q_NEG_LSB, Q_ONE, 1'b1, 1'b1, Q_NEG_LSB, Q_ONE, '0);
    add_row('0, Q_NEG_LSB, 32'h0000_0001, 1'b1, 1'b1, Q_NEG_LSB, Q_ONE, '0);
    add_row('0, 32'h0000_0001, 32'h0000_0001, 1'b1, 1'b1, '0, Q_ONE, '0);
    // Store without result, overwrite the same index, then multiply
    add_row(IDX_W'(5), pick_value(VAL_SMALL), pick_value(VAL_SMALL), 1'b0, 1'b0, '0, '0, '0);
    add_row(IDX_W'(5), pick_value(VAL_SMALL), pick_value(VAL_SMALL), 1'b0, 1'b0, '0, '0, '0);
    add_row(IDX_W'(10), pick_value(VAL_FULL), pick_value(VAL_SMALL), 1'b1, 1'b0, '0, '0, '0);

    // Hold reset, then release on a clock edge
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed rows
    foreach (stim_rows[r])
      load_pair(stim_rows[r], $urandom_range(0, 6));

    // Random matrices: mostly full loads or partial updates ending in last, some stray loads
    while (loads_sent < LOAD_TARGET) begin
      kind = $urandom_range(0, 9);
      burst = ($urandom_range(0, 3) == 0);
      vmode = $urandom_range(VAL_SMALL, VAL_MIXED);
      if (kind <= 5) begin
        n = 16;
        for (i = 0; i < 16; i++) order[i] = i;
        for (i = 15; i > 0; i--) begin
          j = $urandom_range(0, i);
          tmp = order[i];
          order[i] = order[j];
          order[j] = tmp;
        end
      end else begin
        n = (kind == 9) ? $urandom_range(1, 4) : $urandom_range(1, 6);
        for (i = 0; i < n; i++) order[i] = $urandom_range(0, 15);
      end
      for (i = 0; i < n; i++) begin
        row = '0;
        row.idx = IDX_W'(order[i]);
        row.left_val = pick_value(vmode);
        row.right_val = pick_value(vmode);
        row.lst = (kind != 9) && (i == n - 1);
        load_pair(row, burst ? 0 : $urandom_range(0, 6));
      end
    end
    start <= 1'b0;

    // Drain outstanding products, then watch for strays
    while (queued_products.size() != 0 || busy) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("ran %0d element loads and %0d multiplies, %0d product elements checked",
             loads_sent, multiplies, products_seen);
    if (mismatches == 0)
      $display("matrix4x4_multiply_unit: match");
    else
      $display("matrix4x4_multiply_unit: mismatch");
    $finish;
  end

endmodule

`default_nettype wire
